>>> rtl/sis_pkg.sv
`default_nettype none

package sis_pkg;

    localparam int DEPTH_DEF    = 32;
    localparam int ID_WIDTH_DEF = 16;

    localparam int DATA_W = 16;
    localparam int OCC_W  = 6;
    localparam int CMD_W  = 2;
    localparam int STS_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_PUSH   = 2'd1,
        CMD_POP    = 2'd2
    } cmd_t;

    typedef enum logic [STS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } dp_ctl_t;

endpackage

`default_nettype wire

>>> rtl/sis_ctrl.sv
`default_nettype none

module sis_ctrl
    import sis_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output dp_ctl_t      ctl
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
        ctl.load = in_valid && in_ready;
        ctl.exec = (state_reg == S_EXEC);
        out_valid = out_valid_reg;
        if (ctl.exec)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result register must be free whenever a command executes
    a_exec_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec |-> (!out_valid_reg || out_ready))
        else $error("exec while result beat still pending");

    a_exec_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> ctl.exec)
        else $error("accepted beat not executed");

    a_no_load_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec |-> !ctl.load)
        else $error("beat accepted during exec");

endmodule

`default_nettype wire

>>> rtl/sis_dp.sv
`default_nettype none

module sis_dp
    import sis_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int ID_WIDTH = ID_WIDTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dp_ctl_t           ctl,
    input  wire logic [CMD_W-1:0]  command,
    input  wire logic [DATA_W-1:0] data_in,
    output logic [DATA_W-1:0]      data_out,
    output logic [STS_W-1:0]       status,
    output logic [OCC_W-1:0]       occupancy
);

    localparam int CW = $clog2(DEPTH + 1);

    cmd_t                cmd_reg;
    logic [ID_WIDTH-1:0] id_reg;
    logic [ID_WIDTH-1:0] cells_reg [DEPTH];
    logic [ID_WIDTH-1:0] cells_next [DEPTH];
    logic [CW-1:0]       fill_reg, fill_next;
    logic [DATA_W-1:0]   dout_reg, dout_next;
    status_t             sts_reg, sts_next;
    logic [OCC_W-1:0]    occ_reg;

    logic [DEPTH-1:0]    gt;
    logic [DEPTH-1:0]    after;
    logic                full, empty;

    always_comb
    begin
        full  = (fill_reg == CW'(DEPTH));
        empty = (fill_reg == '0);
        for (int k = 0; k < DEPTH; k++)
        begin
            gt[k] = (CW'(k) < fill_reg) && (id_reg < cells_reg[k]);
        end
        // after[k]: slot k lies at or below the insert point
        after[0] = (cmd_reg == CMD_PUSH) || empty || gt[0];
        for (int k = 1; k < DEPTH; k++)
        begin
            after[k] = after[k-1] || (cmd_reg == CMD_PUSH) || (CW'(k) >= fill_reg) || gt[k];
        end
    end

    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
            cells_next[k] = cells_reg[k];
        fill_next = fill_reg;
        dout_next = '0;
        sts_next  = ST_DONE;
        case (cmd_reg)
            CMD_INSERT, CMD_PUSH:
            begin
                if (full)
                    sts_next = ST_FULL;
                else
                begin
                    cells_next[0] = after[0] ? id_reg : cells_reg[0];
                    for (int k = 1; k < DEPTH; k++)
                    begin
                        if (!after[k])
                            cells_next[k] = cells_reg[k];
                        else if (!after[k-1])
                            cells_next[k] = id_reg;
                        else
                            cells_next[k] = cells_reg[k-1];
                    end
                    fill_next = fill_reg + 1'b1;
                end
            end
            CMD_POP:
            begin
                if (empty)
                    sts_next = ST_EMPTY;
                else
                begin
                    dout_next = DATA_W'(cells_reg[0]);
                    for (int k = 0; k < DEPTH - 1; k++)
                        cells_next[k] = cells_reg[k+1];
                    fill_next = fill_reg - 1'b1;
                end
            end
            default:
            begin
                sts_next = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd_t'(command);
            id_reg  <= ID_WIDTH'(data_in);
        end
        if (ctl.exec)
        begin
            for (int k = 0; k < DEPTH; k++)
                cells_reg[k] <= cells_next[k];
            dout_reg <= dout_next;
            sts_reg  <= sts_next;
            occ_reg  <= OCC_W'(fill_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else if (ctl.exec)
            fill_reg <= fill_next;
    end

    assign data_out  = dout_reg;
    assign status    = sts_reg;
    assign occupancy = occ_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("fill count above depth");

    a_fill_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.exec |=> $stable(fill_reg))
        else $error("fill count moved without exec");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.exec && sts_next == ST_FULL) |=> (fill_reg == CW'(DEPTH)))
        else $error("rejected insert changed fill count");

endmodule

`default_nettype wire

>>> rtl/sorted_id_stack_top.sv
// Sorted id stack: up to DEPTH ids held in ascending order, smallest on top.
// Command beats arrive on s_axis (tuser = command: 0 sorted insert, 1 push on
// top, 2 pop; tdata = id). Each command gives exactly one result beat on
// m_axis carrying the popped id (zero unless a pop succeeded), a status
// (0 done, 1 full and rejected, 2 empty on pop) and the occupancy after the
// command. A command is handled in order: the beat is registered, then the
// register array is updated, where every slot compares against the new
// id in parallel and shifts by one. The result sits in an output register;
// a new command is taken only once the previous result beat leaves, at the
// earliest in the same cycle, so a stalled m_axis stalls s_axis. No clearing
// pass after reset; slots beyond the occupancy are never read.
`default_nettype none

module sorted_id_stack_top
    import sis_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int ID_WIDTH = ID_WIDTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] data_in
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [15:0] data_out, [21:16] occupancy, [23:22] 0
    output logic [1:0]       m_axis_tuser    // [1:0] status
);

    dp_ctl_t           ctl;
    logic [DATA_W-1:0] data_out;
    logic [STS_W-1:0]  status;
    logic [OCC_W-1:0]  occupancy;

    sis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .ctl       (ctl)
    );

    sis_dp #(
        .DEPTH    (DEPTH),
        .ID_WIDTH (ID_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .command   (s_axis_tuser),
        .data_in   (s_axis_tdata),
        .data_out  (data_out),
        .status    (status),
        .occupancy (occupancy)
    );

    assign m_axis_tdata = {2'b00, occupancy, data_out};
    assign m_axis_tuser = status;

endmodule

`default_nettype wire
